// File: rtl/clip_stack_damage_tracker_defines.svh
// ---------------------------------------------------------------------------
// Clip stack damage tracker assertion macros
// Shared macros for the concurrent checks of the clip stack damage tracker.
// ---------------------------------------------------------------------------
`ifndef CLIP_STACK_DAMAGE_TRACKER_DEFINES_SVH
`define CLIP_STACK_DAMAGE_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CSDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CSDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/csdt_pkg.sv
// ---------------------------------------------------------------------------
// Clip stack damage tracker package
// Shared constants, command codes and controller/datapath types.
// ---------------------------------------------------------------------------
package csdt_pkg;

  localparam int FB_WIDTH_DEF   = 320;
  localparam int FB_HEIGHT_DEF  = 240;
  localparam int CLIP_DEPTH_DEF = 32;

  localparam int REQ_W   = 3;
  localparam int COORD_W = 16;
  // Working width of the signed coordinate arithmetic.
  localparam int CW      = 18;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_FILL  = 3'd2,
    REQ_PIXEL = 3'd3,
    REQ_MARK  = 3'd4,
    REQ_TAKE  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic mem_rd;
    logic load_top;
  } csdt_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic fetch_needed;
  } csdt_sts_t;

endpackage

// File: rtl/csdt_channels.sv
// ---------------------------------------------------------------------------
// Clip stack damage tracker channels
// Valid/ready interfaces for the command and result words.
// ---------------------------------------------------------------------------
interface csdt_in_if import csdt_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] size_w;
  logic signed [COORD_W-1:0] size_h;

  modport source (output valid, req_type, pos_x, pos_y, size_w, size_h, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, size_w, size_h, output ready);
endinterface

interface csdt_out_if import csdt_pkg::*; #(
  parameter int XW = $clog2(FB_WIDTH_DEF + 1),
  parameter int YW = $clog2(FB_HEIGHT_DEF + 1)
);
  logic          valid;
  logic          ready;
  logic          status;
  logic [XW-1:0] area_x0;
  logic [YW-1:0] area_y0;
  logic [XW-1:0] area_x1;
  logic [YW-1:0] area_y1;
  logic          damage_pending;

  modport source (output valid, status, area_x0, area_y0, area_x1, area_y1, damage_pending,
                  input ready);
  modport sink (input valid, status, area_x0, area_y0, area_x1, area_y1, damage_pending,
                output ready);
endinterface

// File: rtl/csdt_ctrl.sv
// ---------------------------------------------------------------------------
// Clip stack damage tracker controller
// Sequences capture, evaluation and the refetch of the stack top after a pop.
// ---------------------------------------------------------------------------
module csdt_ctrl import csdt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  csdt_sts_t sts,
  output csdt_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = sts.fetch_needed ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE) && !sts.out_busy;
    cmd          = '0;
    cmd.latch_in = in_valid && in_ready;
    cmd.exec     = (state_r == ST_EXEC);
    cmd.mem_rd   = (state_r == ST_READ);
    cmd.load_top = (state_r == ST_LOAD);
  end

endmodule

// File: rtl/csdt_datapath.sv
// ---------------------------------------------------------------------------
// Clip stack damage tracker datapath
// Clip stack memory, cached stack top, damage box and result register.
// ---------------------------------------------------------------------------
module csdt_datapath import csdt_pkg::*; #(
  parameter int FB_WIDTH   = FB_WIDTH_DEF,
  parameter int FB_HEIGHT  = FB_HEIGHT_DEF,
  parameter int CLIP_DEPTH = CLIP_DEPTH_DEF,
  localparam int XW = $clog2(FB_WIDTH + 1),
  localparam int YW = $clog2(FB_HEIGHT + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  csdt_cmd_t                 cmd,
  output csdt_sts_t                 sts,
  input  logic [REQ_W-1:0]          req_type,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] size_w,
  input  logic signed [COORD_W-1:0] size_h,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      status,
  output logic [XW-1:0]             area_x0,
  output logic [YW-1:0]             area_y0,
  output logic [XW-1:0]             area_x1,
  output logic [YW-1:0]             area_y1,
  output logic                      damage_pending
);

  localparam int LW = $clog2(CLIP_DEPTH + 1);
  localparam int AW = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
  localparam int EW = 1 + 2 * XW + 2 * YW;
  localparam logic signed [CW-1:0] FBW = CW'(FB_WIDTH);
  localparam logic signed [CW-1:0] FBH = CW'(FB_HEIGHT);

  logic [REQ_W-1:0]          req_r;
  logic signed [COORD_W-1:0] x_r, y_r, w_r, h_r;

  logic [LW-1:0] level_r, level_nxt, level_m1;
  logic [EW-1:0] top_r, top_nxt, entry_new, rdata_r;
  logic [EW-1:0] mem [CLIP_DEPTH];

  logic          dvalid_r, dvalid_nxt;
  logic [XW-1:0] dmin_x_r, dmin_x_nxt, dmax_x_r, dmax_x_nxt;
  logic [YW-1:0] dmin_y_r, dmin_y_nxt, dmax_y_r, dmax_y_nxt;

  logic          out_valid_r, status_r, pend_r;
  logic [XW-1:0] ax0_r, ax1_r;
  logic [YW-1:0] ay0_r, ay1_r;

  logic          top_en, clip_on, clip_use, size_ok, rect_ok, pix_vis;
  logic [XW-1:0] top_x0, top_x1;
  logic [YW-1:0] top_y0, top_y1;
  logic signed [CW-1:0] tx0, ty0, tx1, ty1;
  logic signed [CW-1:0] px, py, pw, ph, ex1, ey1, px1, py1;
  logic signed [CW-1:0] cx0, cy0, cx1, cy1, rx0, ry0, rx1, ry1;

  logic          ok, wr_en, dmg_add, dmg_clear;
  logic [XW-1:0] ax0, ax1;
  logic [YW-1:0] ay0, ay1;

  assign top_en = top_r[EW-1];
  assign top_x0 = top_r[EW-2 -: XW];
  assign top_y0 = top_r[EW-2-XW -: YW];
  assign top_x1 = top_r[XW+YW-1 -: XW];
  assign top_y1 = top_r[YW-1:0];

  assign tx0 = signed'({{(CW-XW){1'b0}}, top_x0});
  assign tx1 = signed'({{(CW-XW){1'b0}}, top_x1});
  assign ty0 = signed'({{(CW-YW){1'b0}}, top_y0});
  assign ty1 = signed'({{(CW-YW){1'b0}}, top_y1});

  assign px  = signed'({{(CW-COORD_W){x_r[COORD_W-1]}}, x_r});
  assign py  = signed'({{(CW-COORD_W){y_r[COORD_W-1]}}, y_r});
  assign pw  = signed'({{(CW-COORD_W){w_r[COORD_W-1]}}, w_r});
  assign ph  = signed'({{(CW-COORD_W){h_r[COORD_W-1]}}, h_r});
  assign ex1 = px + pw;
  assign ey1 = py + ph;
  assign px1 = px + CW'(1);
  assign py1 = py + CW'(1);

  assign clip_on  = (level_r != '0) && top_en;
  assign clip_use = clip_on && ((req_r == REQ_PUSH) || (req_r == REQ_FILL));
  assign size_ok  = (w_r > 16'sd0) && (h_r > 16'sd0);

  always_comb begin
    cx0 = px[CW-1] ? '0 : px;
    cy0 = py[CW-1] ? '0 : py;
    cx1 = (ex1 > FBW) ? FBW : ex1;
    cy1 = (ey1 > FBH) ? FBH : ey1;
    rx0 = cx0;
    ry0 = cy0;
    rx1 = cx1;
    ry1 = cy1;
    if (clip_use) begin
      rx0 = (cx0 > tx0) ? cx0 : tx0;
      ry0 = (cy0 > ty0) ? cy0 : ty0;
      rx1 = (cx1 < tx1) ? cx1 : tx1;
      ry1 = (cy1 < ty1) ? cy1 : ty1;
    end
  end

  assign rect_ok = size_ok && (rx1 > rx0) && (ry1 > ry0);
  assign pix_vis = !px[CW-1] && (px < FBW) && !py[CW-1] && (py < FBH) &&
                   (!clip_on || ((px >= tx0) && (px < tx1) && (py >= ty0) && (py < ty1)));
  assign entry_new = rect_ok ? {1'b1, rx0[XW-1:0], ry0[YW-1:0], rx1[XW-1:0], ry1[YW-1:0]}
                             : '0;
  assign level_m1 = level_r - LW'(1);

  always_comb begin
    ok        = 1'b0;
    wr_en     = 1'b0;
    dmg_add   = 1'b0;
    dmg_clear = 1'b0;
    level_nxt = level_r;
    top_nxt   = top_r;
    ax0       = '0;
    ay0       = '0;
    ax1       = '0;
    ay1       = '0;
    unique case (req_r)
      REQ_PUSH: begin
        if (level_r != LW'(CLIP_DEPTH)) begin
          wr_en     = 1'b1;
          level_nxt = level_r + LW'(1);
          top_nxt   = entry_new;
          if (rect_ok) begin
            ok  = 1'b1;
            ax0 = rx0[XW-1:0];
            ay0 = ry0[YW-1:0];
            ax1 = rx1[XW-1:0];
            ay1 = ry1[YW-1:0];
          end
        end
      end
      REQ_POP: begin
        if (level_r != '0) begin
          level_nxt = level_m1;
          ok        = 1'b1;
        end
      end
      REQ_FILL, REQ_MARK: begin
        if (rect_ok) begin
          ok      = 1'b1;
          dmg_add = 1'b1;
          ax0     = rx0[XW-1:0];
          ay0     = ry0[YW-1:0];
          ax1     = rx1[XW-1:0];
          ay1     = ry1[YW-1:0];
        end
      end
      REQ_PIXEL: begin
        if (pix_vis) begin
          ok      = 1'b1;
          dmg_add = 1'b1;
          ax0     = px[XW-1:0];
          ay0     = py[YW-1:0];
          ax1     = px1[XW-1:0];
          ay1     = py1[YW-1:0];
        end
      end
      REQ_TAKE: begin
        if (dvalid_r) begin
          ok        = 1'b1;
          dmg_clear = 1'b1;
          ax0       = dmin_x_r;
          ay0       = dmin_y_r;
          ax1       = dmax_x_r;
          ay1       = dmax_y_r;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    dvalid_nxt = dvalid_r;
    dmin_x_nxt = dmin_x_r;
    dmin_y_nxt = dmin_y_r;
    dmax_x_nxt = dmax_x_r;
    dmax_y_nxt = dmax_y_r;
    priority if (dmg_clear) begin
      dvalid_nxt = 1'b0;
      dmin_x_nxt = XW'(FB_WIDTH);
      dmin_y_nxt = YW'(FB_HEIGHT);
      dmax_x_nxt = '0;
      dmax_y_nxt = '0;
    end else if (dmg_add && !dvalid_r) begin
      dvalid_nxt = 1'b1;
      dmin_x_nxt = ax0;
      dmin_y_nxt = ay0;
      dmax_x_nxt = ax1;
      dmax_y_nxt = ay1;
    end else if (dmg_add) begin
      dmin_x_nxt = (ax0 < dmin_x_r) ? ax0 : dmin_x_r;
      dmin_y_nxt = (ay0 < dmin_y_r) ? ay0 : dmin_y_r;
      dmax_x_nxt = (ax1 > dmax_x_r) ? ax1 : dmax_x_r;
      dmax_y_nxt = (ay1 > dmax_y_r) ? ay1 : dmax_y_r;
    end
  end

  assign sts.out_busy     = out_valid_r && !out_ready;
  assign sts.fetch_needed = (req_r == REQ_POP) && (level_r > LW'(1));

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[level_r[AW-1:0]] <= entry_new;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[level_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r <= req_type;
      x_r   <= pos_x;
      y_r   <= pos_y;
      w_r   <= size_w;
      h_r   <= size_h;
    end
    if (cmd.exec) begin
      status_r <= !ok;
      ax0_r    <= ax0;
      ay0_r    <= ay0;
      ax1_r    <= ax1;
      ay1_r    <= ay1;
      pend_r   <= dmg_clear || dvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      top_r       <= '0;
      dvalid_r    <= 1'b0;
      dmin_x_r    <= XW'(FB_WIDTH);
      dmin_y_r    <= YW'(FB_HEIGHT);
      dmax_x_r    <= '0;
      dmax_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        level_r  <= level_nxt;
        top_r    <= top_nxt;
        dvalid_r <= dvalid_nxt;
        dmin_x_r <= dmin_x_nxt;
        dmin_y_r <= dmin_y_nxt;
        dmax_x_r <= dmax_x_nxt;
        dmax_y_r <= dmax_y_nxt;
      end else if (cmd.load_top) begin
        top_r <= rdata_r;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign status         = status_r;
  assign area_x0        = ax0_r;
  assign area_y0        = ay0_r;
  assign area_x1        = ax1_r;
  assign area_y1        = ay1_r;
  assign damage_pending = pend_r;

endmodule

// File: rtl/clip_stack_damage_tracker.sv
// ---------------------------------------------------------------------------
// Clip stack damage tracker
// Clip rectangle stack with framebuffer clamping and a damage bounding box.
// ---------------------------------------------------------------------------
// A command word is accepted when the block is idle and its result register
// is empty or being read out in the same cycle. The command is captured at
// acceptance and evaluated in the next cycle against the cached stack top and
// the damage box, and the result word is registered from that evaluation. The
// block takes no new command word until it is idle again. A pop that leaves
// entries on the stack also passes through the READ and LOAD states, since the
// new top is read back from the stack memory through its registered read port.
// The stack memory is not cleared at reset; only entries below the current
// stack level are ever read.
module clip_stack_damage_tracker import csdt_pkg::*; #(
  parameter int FB_WIDTH   = FB_WIDTH_DEF,
  parameter int FB_HEIGHT  = FB_HEIGHT_DEF,
  parameter int CLIP_DEPTH = CLIP_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  csdt_in_if.sink      in_ch,
  csdt_out_if.source   out_ch
);

  csdt_cmd_t cmd;
  csdt_sts_t sts;

  csdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csdt_datapath #(
    .FB_WIDTH   (FB_WIDTH),
    .FB_HEIGHT  (FB_HEIGHT),
    .CLIP_DEPTH (CLIP_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (in_ch.req_type),
    .pos_x          (in_ch.pos_x),
    .pos_y          (in_ch.pos_y),
    .size_w         (in_ch.size_w),
    .size_h         (in_ch.size_h),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .status         (out_ch.status),
    .area_x0        (out_ch.area_x0),
    .area_y0        (out_ch.area_y0),
    .area_x1        (out_ch.area_x1),
    .area_y1        (out_ch.area_y1),
    .damage_pending (out_ch.damage_pending)
  );

endmodule

// File: rtl/csdt_checker.sv
// ---------------------------------------------------------------------------
// Clip stack damage tracker checker
// Port-level checks on handshake timing and result consistency.
// ---------------------------------------------------------------------------
`include "clip_stack_damage_tracker_defines.svh"

module csdt_checker #(
  parameter int XW = 9,
  parameter int YW = 8
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic          status,
  input logic [XW-1:0] area_x0,
  input logic [YW-1:0] area_y0,
  input logic [XW-1:0] area_x1,
  input logic [YW-1:0] area_y1
);

  logic in_acc;
  logic acc_live;
  logic area_zero;
  logic area_order;
  logic ok_area;

  assign in_acc     = in_valid && in_ready;
  assign acc_live   = in_acc && rst_n;
  assign area_zero  = (area_x0 == '0) && (area_y0 == '0) &&
                      (area_x1 == '0) && (area_y1 == '0);
  assign area_order = (area_x1 > area_x0) && (area_y1 > area_y0);
  // A done pop reports a zero area, so only nonzero areas are ordered.
  assign ok_area    = out_valid && !status && (area_x1 != '0);

  `CSDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
  `CSDT_ASSERT_NOW(a_fail_zero, out_valid && status, area_zero, "failed result has nonzero area")
  `CSDT_ASSERT_NOW(a_ok_order, ok_area, area_order, "reported area is empty")
  `CSDT_ASSERT_NEXT(a_busy, in_acc, !in_ready, "command accepted while busy")
  `CSDT_ASSERT_NOW(a_result_due, $past(acc_live, 2) && $past(rst_n), out_valid, "result word late")

endmodule

bind clip_stack_damage_tracker csdt_checker #(
  .XW ($clog2(FB_WIDTH + 1)),
  .YW ($clog2(FB_HEIGHT + 1))
) u_csdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .area_x0   (out_ch.area_x0),
  .area_y0   (out_ch.area_y0),
  .area_x1   (out_ch.area_x1),
  .area_y1   (out_ch.area_y1)
);
